/* hw/rtl/sws_pkg.sv */
// ----------------------------------------------------------------------------
// sws_pkg
// types and constants shared by the sliding window statistics block
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int unsigned WindowMaxDefault  = 256;
  localparam int unsigned SampleBitsDefault = 16;
  localparam int unsigned HopLimit          = 4096;
  localparam int unsigned ValueBits         = 33;
  localparam int unsigned CountBits         = 9;
  localparam int unsigned HopBits           = 13;
  localparam int unsigned CfgIdxBits        = 2;
  localparam int unsigned CfgDataBits       = 13;

  localparam logic [CfgIdxBits-1:0] CfgWindow   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgHop      = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgMinValid = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgMode     = 2'd3;

  typedef enum logic [1:0] {
    ModeMean = 2'd0,
    ModeVar  = 2'd1,
    ModeMax  = 2'd2,
    ModeMin  = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [SampleBitsDefault-1:0] sample;
    logic                                sample_valid;
    logic                                series_end;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] value;
    logic                        value_valid;
    logic [CountBits-1:0]        valid_count;
    logic                        final_result;
  } out_item_t;

endpackage

/* hw/rtl/sws_divider.sv */
// ----------------------------------------------------------------------------
// sws_divider
// restoring radix-2 unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sws_divider #(
  parameter int unsigned NumBits = 64,
  parameter int unsigned DenBits = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quo_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quo_q[NumBits-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

/* hw/rtl/sws_front.sv */
// ----------------------------------------------------------------------------
// sws_front
// takes samples, writes the store, tracks hop phase and issues window jobs
// ----------------------------------------------------------------------------
module sws_front #(
  parameter int unsigned WindowMax  = 256,
  parameter int unsigned SampleBits = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SampleBits-1:0]      sample_i,
  input  logic                              sample_valid_i,
  input  logic                              series_end_i,
  input  logic [8:0]                        window_length_i,
  input  logic [12:0]                       hop_i,
  input  logic                              store_busy_i,
  input  logic                              job_ready_i,
  output logic                              job_valid_o,
  output logic [$clog2(WindowMax+1)-1:0]    job_count_o,
  output logic [$clog2(WindowMax)-1:0]      job_end_o,
  output logic                              job_final_o,
  output logic                              wr_en_o,
  output logic [$clog2(WindowMax)-1:0]      wr_addr_o,
  output logic [SampleBits:0]               wr_data_o
);
  import sws_pkg::*;
  localparam int unsigned AddrBits = $clog2(WindowMax);
  localparam int unsigned NBits    = $clog2(WindowMax + 1);

  logic [AddrBits-1:0] wpos_q;
  logic [NBits-1:0]    seen_q, seen_inc;
  logic [12:0]         phase_q, phase_inc;
  logic [12:0]         h;
  logic [12:0]         w, r;
  logic [12:0]         cnt;
  logic                boundary, fire, take;
  logic                jvalid_q;
  logic [NBits-1:0]    jcount_q;
  logic [AddrBits-1:0] jend_q;
  logic                jfinal_q;

  always_comb begin
    h = (hop_i == '0) ? 13'd1 : ((hop_i > 13'(HopLimit)) ? 13'(HopLimit) : hop_i);
    w = (window_length_i == '0) ? 13'd1 : 13'(window_length_i);
    if (w > 13'(WindowMax)) w = 13'(WindowMax);
    seen_inc  = (seen_q == NBits'(WindowMax)) ? seen_q : seen_q + 1'b1;
    phase_inc = phase_q + 1'b1;
    boundary  = phase_inc >= h;
    fire      = boundary || series_end_i;
    r         = h - phase_inc;
    if (boundary) cnt = w;
    else          cnt = (w > r) ? (w - r) : '0;
    if (cnt > 13'(seen_inc)) cnt = 13'(seen_inc);
  end

  // no store writes while the back end walks the window
  assign in_ready_o = !jvalid_q && !store_busy_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q   <= '0;
      seen_q   <= '0;
      phase_q  <= '0;
      jvalid_q <= 1'b0;
      jcount_q <= '0;
      jend_q   <= '0;
      jfinal_q <= 1'b0;
    end else begin
      if (jvalid_q && job_ready_i) jvalid_q <= 1'b0;
      if (take) begin
        wpos_q <= wpos_q + 1'b1;
        if (series_end_i) begin
          seen_q  <= '0;
          phase_q <= '0;
        end else begin
          seen_q  <= seen_inc;
          phase_q <= boundary ? '0 : phase_inc;
        end
        if (fire) begin
          jvalid_q <= 1'b1;
          jcount_q <= NBits'(cnt);
          jend_q   <= wpos_q;
          jfinal_q <= series_end_i;
        end
      end
    end
  end

  assign job_valid_o = jvalid_q;
  assign job_count_o = jcount_q;
  assign job_end_o   = jend_q;
  assign job_final_o = jfinal_q;
  assign wr_en_o     = take;
  assign wr_addr_o   = wpos_q;
  assign wr_data_o   = {sample_valid_i, sample_i};
endmodule

/* hw/rtl/sws_back.sv */
// ----------------------------------------------------------------------------
// sws_back
// walks the window through the store, accumulates and forms the result
// ----------------------------------------------------------------------------
module sws_back #(
  parameter int unsigned WindowMax  = 256,
  parameter int unsigned SampleBits = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  output logic                           job_ready_o,
  input  logic [$clog2(WindowMax+1)-1:0] job_count_i,
  input  logic [$clog2(WindowMax)-1:0]   job_end_i,
  input  logic                           job_final_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(WindowMax)-1:0]   wr_addr_i,
  input  logic [SampleBits:0]            wr_data_i,
  input  logic [8:0]                     min_valid_i,
  input  logic [1:0]                     mode_i,
  output logic                           store_busy_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sws_pkg::out_item_t             out_item_o
);
  import sws_pkg::*;
  localparam int unsigned AddrBits = $clog2(WindowMax);
  localparam int unsigned NBits    = $clog2(WindowMax + 1);
  localparam int unsigned SumBits  = SampleBits + NBits + 1;
  localparam int unsigned SqBits   = 2 * SampleBits + NBits;
  localparam int unsigned NumBits  = 2 * SampleBits + 2 * NBits + 2;
  localparam int unsigned DenBits  = 2 * NBits;

  typedef enum logic [2:0] {
    StIdle, StWalk, StDrain, StMul, StSub, StDiv, StOut
  } state_e;

  logic [SampleBits:0] mem [WindowMax];
  logic [SampleBits:0] rd_q;

  state_e                         st_q;
  logic [NBits-1:0]               left_q, n_q;
  logic [AddrBits-1:0]            addr_q;
  logic                           rdv_q, final_q;
  logic signed [SumBits-1:0]      sum_q;
  logic [SqBits-1:0]              sq_q;
  logic signed [SampleBits-1:0]   hi_q, lo_q;
  logic signed [NumBits-1:0]      a_q, b_q, num_c;
  logic [DenBits-1:0]             den_q;
  logic                           neg_q, ok_q;
  logic                           div_start;
  logic                           div_done;
  logic [NumBits-1:0]             quo;
  logic                           ovalid_q;
  out_item_t                      oitem_q;
  logic signed [SampleBits-1:0]   x;
  logic signed [2*SampleBits-1:0] xsq;
  logic signed [SumBits-1:0]      absum;
  logic [ValueBits-1:0]           qsat;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_q <= mem[addr_q];
  end

  assign x     = rd_q[SampleBits-1:0];
  assign xsq   = x * x;
  assign absum = sum_q[SumBits-1] ? -sum_q : sum_q;
  assign num_c = (mode_i == ModeVar) ? a_q - b_q : NumBits'(absum);
  assign div_start = (st_q == StSub);
  assign qsat = (quo > NumBits'(33'h0_FFFF_FFFF)) ? 33'h0_FFFF_FFFF : ValueBits'(quo);

  sws_divider #(.NumBits(NumBits), .DenBits(DenBits)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (NumBits'(num_c)),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign job_ready_o  = (st_q == StIdle) && !ovalid_q;
  assign store_busy_o = (st_q == StWalk);
  assign out_valid_o  = ovalid_q;
  assign out_item_o   = oitem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      ovalid_q <= 1'b0;
      rdv_q    <= 1'b0;
      left_q   <= '0;
      n_q      <= '0;
      addr_q   <= '0;
      final_q  <= 1'b0;
      ok_q     <= 1'b0;
      neg_q    <= 1'b0;
      sum_q    <= '0;
      sq_q     <= '0;
      hi_q     <= '0;
      lo_q     <= '0;
      a_q      <= '0;
      b_q      <= '0;
      oitem_q  <= '0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (job_valid_i && job_ready_o) begin
            left_q  <= job_count_i;
            addr_q  <= job_end_i;
            final_q <= job_final_i;
            n_q     <= '0;
            sum_q   <= '0;
            sq_q    <= '0;
            rdv_q   <= 1'b0;
            st_q    <= StWalk;
          end
        end
        StWalk, StDrain: begin
          rdv_q <= (st_q == StWalk) && (left_q != '0);
          if (st_q == StWalk && left_q != '0) begin
            left_q <= left_q - 1'b1;
            addr_q <= addr_q - 1'b1;
          end
          if (st_q == StWalk && left_q == '0) st_q <= StDrain;
          if (st_q == StDrain) st_q <= StMul;
          if (rdv_q && rd_q[SampleBits]) begin
            n_q   <= n_q + 1'b1;
            sum_q <= sum_q + SumBits'(x);
            sq_q  <= sq_q + SqBits'(unsigned'(xsq));
            if (n_q == '0 || x > hi_q) hi_q <= x;
            if (n_q == '0 || x < lo_q) lo_q <= x;
          end
        end
        StMul: begin
          ok_q <= (n_q != '0) && (9'(n_q) >= min_valid_i) &&
                  !(mode_i == ModeVar && n_q < NBits'(2));
          a_q  <= NumBits'(n_q) * NumBits'(sq_q);
          b_q  <= NumBits'(unsigned'(absum)) * NumBits'(unsigned'(absum));
          neg_q <= sum_q[SumBits-1];
          st_q <= StSub;
        end
        StSub: begin
          st_q <= StDiv;
        end
        StDiv: begin
          if (div_done) st_q <= StOut;
        end
        StOut: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            oitem_q.valid_count  <= 9'(n_q);
            oitem_q.final_result <= final_q;
            oitem_q.value_valid  <= ok_q;
            if (ok_q) begin
              unique case (mode_e'(mode_i))
                ModeMean: oitem_q.value <= neg_q ? -signed'(ValueBits'(quo))
                                                 : signed'(ValueBits'(quo));
                ModeVar:  oitem_q.value <= signed'(qsat);
                ModeMax:  oitem_q.value <= ValueBits'(hi_q);
                ModeMin:  oitem_q.value <= ValueBits'(lo_q);
                default:  oitem_q.value <= '0;
              endcase
            end else begin
              oitem_q.value <= '0;
            end
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StMul) begin
      if (mode_i == ModeVar) begin
        den_q <= DenBits'(n_q) * DenBits'(n_q - 1'b1);
      end else begin
        den_q <= (n_q == '0) ? DenBits'(1) : DenBits'(n_q);
      end
    end
  end
endmodule

/* hw/rtl/sliding_window_statistics_core.sv */
// ----------------------------------------------------------------------------
// sliding_window_statistics_core
// hopped sliding window mean, variance, maximum and minimum
// ----------------------------------------------------------------------------
// samples enter on the in channel (valid/ready) and are written to a ring
// store; every hop-th sample and the series end raise a window request.
// a one-entry request register parts the front from the back end.
// the back end walks the window one store entry per cycle, then runs a
// radix-2 divider, one quotient bit per cycle.
// input is held off while the back end walks the store and while a window
// request waits in the request register for the back end to take it.
// results leave on the out channel through an output register; when the
// receiver stalls the back end holds and the front fills, then stops input.
// reset clears all counters and sets window 24, hop 1, min_valid 0, mean.
// the store needs no clearing: entries are read only after being written.
// configuration writes take effect at once and belong while idle.
// ----------------------------------------------------------------------------
module sliding_window_statistics_core #(
  parameter int unsigned WindowMax  = sws_pkg::WindowMaxDefault,
  parameter int unsigned SampleBits = sws_pkg::SampleBitsDefault
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [sws_pkg::CfgIdxBits-1:0]           cfg_idx_i,
  input  logic [sws_pkg::CfgDataBits-1:0]          cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  sws_pkg::in_item_t                        in_item_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output sws_pkg::out_item_t                       out_item_o
);
  import sws_pkg::*;
  localparam int unsigned AddrBits = $clog2(WindowMax);
  localparam int unsigned NBits    = $clog2(WindowMax + 1);

  logic [8:0]  window_q;
  logic [12:0] hop_q;
  logic [8:0]  minv_q;
  logic [1:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 9'd24;
      hop_q    <= 13'd1;
      minv_q   <= '0;
      mode_q   <= ModeMean;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindow:   window_q <= cfg_data_i[8:0];
        CfgHop:      hop_q    <= cfg_data_i;
        CfgMinValid: minv_q   <= cfg_data_i[8:0];
        CfgMode:     mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic                job_valid, job_ready, job_final, wr_en, store_busy;
  logic [NBits-1:0]    job_count;
  logic [AddrBits-1:0] job_end, wr_addr;
  logic [SampleBits:0] wr_data;

  sws_front #(.WindowMax(WindowMax), .SampleBits(SampleBits)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_i        (SampleBits'(in_item_i.sample)),
    .sample_valid_i  (in_item_i.sample_valid),
    .series_end_i    (in_item_i.series_end),
    .window_length_i (window_q),
    .hop_i           (hop_q),
    .store_busy_i    (store_busy),
    .job_ready_i     (job_ready),
    .job_valid_o     (job_valid),
    .job_count_o     (job_count),
    .job_end_o       (job_end),
    .job_final_o     (job_final),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  sws_back #(.WindowMax(WindowMax), .SampleBits(SampleBits)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i  (job_valid),
    .job_ready_o  (job_ready),
    .job_count_i  (job_count),
    .job_end_i    (job_end),
    .job_final_i  (job_final),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_data_i    (wr_data),
    .min_valid_i  (minv_q),
    .mode_i       (mode_q),
    .store_busy_o (store_busy),
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );
endmodule

/* test/sliding_window_statistics_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_statistics_core_tb
// self-checking bench for the hopped sliding window statistics core
// ----------------------------------------------------------------------------
// a driver feeds sample requests from a queue and a monitor checks every
// window result against an in-bench model of the ring store, hop counter
// and reductions. the run steps through several register settings,
// including out-of-range window and hop values, and three idling profiles.
// ----------------------------------------------------------------------------
module sliding_window_statistics_core_tb;
  import sws_pkg::*;

  localparam int unsigned Depth     = 256;
  localparam int unsigned Drain     = 400;
  localparam int unsigned CycleLimit = 2000000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  in_item_t               in_item_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  out_item_t              out_item_o;

  sliding_window_statistics_core dut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  logic signed [15:0] ring_val [Depth];
  logic               ring_ok  [Depth];
  int unsigned        ring_wr = 0;
  int unsigned        phase_cnt = 0;
  int unsigned        seen_cnt = 0;
  int unsigned        win_reg = 24;
  int unsigned        hop_reg = 1;
  int unsigned        minv_reg = 0;
  mode_e              mode_reg = ModeMean;

  in_item_t    sample_q [$];
  out_item_t   window_q [$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic void window_result(in_item_t it);
    int unsigned w, h, cnt, r, n, idx;
    logic        boundary, ok;
    longint      sum, hi, lo, x;
    logic [63:0] usum, usq, num, q;
    out_item_t   o;
    w = (win_reg < 1) ? 1 : (win_reg > Depth) ? Depth : win_reg;
    h = (hop_reg < 1) ? 1 : (hop_reg > HopLimit) ? HopLimit : hop_reg;
    ring_val[ring_wr] = it.sample;
    ring_ok[ring_wr]  = it.sample_valid;
    ring_wr = (ring_wr + 1) % Depth;
    if (seen_cnt < Depth) seen_cnt++;
    phase_cnt++;
    boundary = (phase_cnt >= h);
    if (!boundary && !it.series_end) return;
    if (boundary) begin
      cnt = w;
    end else begin
      r = h - phase_cnt;
      cnt = (w > r) ? w - r : 0;
    end
    if (cnt > seen_cnt) cnt = seen_cnt;
    n = 0; sum = 0; hi = 0; lo = 0; usum = 0; usq = 0;
    for (int unsigned k = 0; k < cnt; k++) begin
      idx = (ring_wr + Depth - 1 - k) % Depth;
      if (ring_ok[idx]) begin
        x = ring_val[idx];
        if (n == 0) begin
          hi = x; lo = x;
        end else begin
          if (x > hi) hi = x;
          if (x < lo) lo = x;
        end
        n++;
        sum += x;
        usum += 64'(x);
        usq += 64'(x * x);
      end
    end
    ok = (n > 0) && (n >= minv_reg);
    if (mode_reg == ModeVar && n < 2) ok = 1'b0;
    o = '0;
    if (ok) begin
      case (mode_reg)
        ModeMean: o.value = 33'(sum / longint'(n));
        ModeVar: begin
          num = 64'(n) * usq - usum * usum;
          q = num / (64'(n) * 64'(n - 1));
          if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
          o.value = 33'(q);
        end
        ModeMax: o.value = 33'(hi);
        default: o.value = 33'(lo);
      endcase
    end
    o.value_valid  = ok;
    o.valid_count  = 9'(n);
    o.final_result = it.series_end;
    window_q.push_back(o);
    if (boundary) phase_cnt = 0;
    if (it.series_end) begin
      phase_cnt = 0;
      seen_cnt = 0;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) window_result(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_item_i  <= sample_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (window_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item_o);
        end else begin
          e = window_q.pop_front();
          if (e.value !== out_item_o.value || e.value_valid !== out_item_o.value_valid ||
              e.valid_count !== out_item_o.valid_count ||
              e.final_result !== out_item_o.final_result) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_item_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sliding_window_statistics_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataBits'(val);
    case (idx)
      CfgWindow:   win_reg  = val & 9'h1FF;
      CfgHop:      hop_reg  = val & 13'h1FFF;
      CfgMinValid: minv_reg = val & 9'h1FF;
      default:     mode_reg = mode_e'(val & 2'h3);
    endcase
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned mv, mode_e md);
    write_reg(CfgWindow, w);
    write_reg(CfgHop, h);
    write_reg(CfgMinValid, mv);
    write_reg(CfgMode, md);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(logic signed [15:0] s, logic v, logic last);
    in_item_t it;
    it.sample = s;
    it.sample_valid = v;
    it.series_end = last;
    sample_q.push_back(it);
  endtask

  task automatic push_random(int unsigned n, int unsigned end_pct);
    logic signed [15:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: s = 16'sh7FFF;
        1: s = 16'sh8000;
        2: s = 16'(int'($urandom_range(20)) - 10);
        default: s = 16'($urandom);
      endcase
      push_sample(s, $urandom_range(99) < 80, $urandom_range(99) < end_pct);
    end
  endtask

  task automatic settle();
    while (sample_q.size() > 0 || in_valid_i || window_q.size() > 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 30;
    recv_idle = 86;
    // reset settings, extremes and missing samples
    push_sample(16'sh7FFF, 1, 0);
    push_sample(16'sh8000, 1, 0);
    push_sample(16'sh7FFF, 1, 0);
    push_sample(16'sh0000, 0, 0);
    push_sample(-16'sd1, 1, 1);
    push_sample(16'sh1234, 0, 0);
    push_sample(16'sh4321, 0, 1);
    push_sample(16'sh8000, 1, 1);
    push_sample(-16'sd7, 1, 0);
    push_sample(16'sd7, 1, 0);
    push_sample(-16'sd3, 1, 0);
    push_sample(16'sh5555, 1, 0);
    push_sample(16'shAAAA, 1, 1);
    push_random(7, 10);
    settle();
    setup(1, 1, 0, ModeVar);
    push_random(100, 3);
    settle();
    setup(256, 1, 0, ModeMax);
    push_random(60, 1);
    settle();
    setup(8, 3, 2, ModeMin);
    push_random(300, 3);
    settle();
    send_idle = 86;
    recv_idle = 30;
    setup(16, 5, 0, ModeVar);
    push_random(300, 3);
    settle();
    setup(256, 4096, 256, ModeMean);
    push_random(100, 5);
    settle();
    setup(0, 0, 300, ModeMax);
    push_random(100, 3);
    settle();
    setup(511, 8191, 0, ModeVar);
    push_random(100, 6);
    settle();
    send_idle = 0;
    recv_idle = 0;
    setup(32, 7, 4, ModeMean);
    push_random(300, 3);
    settle();
    setup(12, 2, 1, ModeMax);
    push_random(300, 3);
    settle();
    setup(5, 6, 0, ModeMin);
    push_random(300, 3);
    settle();
    if (mismatches == 0) begin
      $display("sliding_window_statistics_core verification clean");
    end else begin
      $display("sliding_window_statistics_core verification failed");
    end
    $finish;
  end

endmodule
